// File: rtl/mapd_pkg.sv
package mapd_pkg;

	// Sample and average width
	localparam int DATA_W = 16;
	// Default window length as a power of two (window of 8 samples)
	localparam int WINDOW_LOG2_DEF = 3;
	// Position counter: signed, spans minus the window up to the saturation point
	localparam int POS_W = 18;
	localparam int POS_LIMIT = 65536;
	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] REG_PEAK_THRESHOLD = 3'd0;

	// Shift control for the window cells and the statistics unit
	typedef struct packed {
		logic adv;   // accepted beat, shift the window
		logic clr;   // restart, drop the window contents
	} mapd_ctl_t;

	typedef struct packed {
		logic [DATA_W-1:0] average;
		logic              average_valid;
		logic              peak_found;
		logic [DATA_W-1:0] peak_index;
	} mapd_res_t;

endpackage

// File: rtl/mapd_in_if.sv
interface mapd_in_if;
	logic                        valid;
	logic                        ready;
	logic [mapd_pkg::DATA_W-1:0] sample;
	logic                        restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink (input valid, input sample, input restart, output ready);
endinterface

// File: rtl/mapd_out_if.sv
interface mapd_out_if;
	logic                        valid;
	logic                        ready;
	logic [mapd_pkg::DATA_W-1:0] average;
	logic                        average_valid;
	logic                        peak_found;
	logic [mapd_pkg::DATA_W-1:0] peak_index;

	modport source (output valid, output average, output average_valid,
		output peak_found, output peak_index, input ready);
	modport sink (input valid, input average, input average_valid,
		input peak_found, input peak_index, output ready);
endinterface

// File: rtl/mapd_cell.sv
module mapd_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mapd_pkg::mapd_ctl_t         ctl,
	input  logic [mapd_pkg::DATA_W-1:0] d,
	output logic [mapd_pkg::DATA_W-1:0] q
);

	logic [mapd_pkg::DATA_W-1:0] tap_q;

	// Take the neighbor's sample on every beat; restart empties the cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (ctl.adv) begin
			tap_q <= ctl.clr ? '0 : d;
		end
	end

	assign q = tap_q;

endmodule

// File: rtl/mapd_stat.sv
module mapd_stat #(
	parameter int WINDOW_LOG2 = mapd_pkg::WINDOW_LOG2_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mapd_pkg::mapd_ctl_t         ctl,
	input  logic [mapd_pkg::DATA_W-1:0] sample,
	input  logic [mapd_pkg::DATA_W-1:0] oldest,
	input  logic [mapd_pkg::DATA_W-1:0] threshold,
	output mapd_pkg::mapd_res_t         res
);

	localparam int SUM_W = mapd_pkg::DATA_W + WINDOW_LOG2;
	localparam int POS_W = mapd_pkg::POS_W;
	localparam int DW = mapd_pkg::DATA_W;
	localparam logic signed [POS_W-1:0] POS_INIT = POS_W'(-(1 << WINDOW_LOG2));
	localparam logic signed [POS_W-1:0] POS_TOP = POS_W'(mapd_pkg::POS_LIMIT);

	logic [SUM_W-1:0]        sum_q, sum_base, sum_next;
	logic signed [POS_W-1:0] pos_q, pos_base, pos_next, idx_full;
	logic [DW-1:0]           prev_q, older_q, prev_base, older_base;
	logic [DW-1:0]           old_smp, avg;
	logic                    valid, peak;

	always_comb begin
		sum_base   = ctl.clr ? '0 : sum_q;
		old_smp    = ctl.clr ? '0 : oldest;
		pos_base   = ctl.clr ? POS_INIT : pos_q;
		prev_base  = ctl.clr ? '0 : prev_q;
		older_base = ctl.clr ? '0 : older_q;
		// The leaving sample is part of the sum, so this never wraps
		sum_next   = sum_base + SUM_W'(sample) - SUM_W'(old_smp);
		pos_next   = (pos_base < POS_TOP) ? pos_base + POS_W'(1) : pos_base;
		idx_full   = pos_next - POS_W'(1);
		valid      = !pos_next[POS_W-1];
		avg        = sum_next[SUM_W-1 -: DW];
		peak       = valid && (older_base <= prev_base) && (avg < prev_base)
			&& (prev_base >= threshold);
		res.average       = valid ? avg : '0;
		res.average_valid = valid;
		res.peak_found    = peak;
		res.peak_index    = (peak && (pos_next != '0)) ? idx_full[DW-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			pos_q   <= POS_INIT;
			prev_q  <= '0;
			older_q <= '0;
		end else if (ctl.adv) begin
			sum_q   <= sum_next;
			pos_q   <= pos_next;
			// Averages only age once the window is full
			prev_q  <= valid ? avg : prev_base;
			older_q <= valid ? prev_base : older_base;
		end
	end

endmodule

// File: rtl/moving_average_peak_detector.sv
// Moving average with local maximum detection.
// A result beat is offered in the cycle after its sample beat is accepted.
// Throughput: one sample per cycle while the result side does not stall; the window
// shift, running sum and peak compare add no register between input and result register.
// Reset (arst_n low): window cells, running sum, averages and threshold clear,
// position counter loads minus the window length; no result beat is pending.
module moving_average_peak_detector #(
	parameter int WINDOW_LOG2 = mapd_pkg::WINDOW_LOG2_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mapd_in_if.sink                      samples,
	mapd_out_if.source                   results,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mapd_pkg::PADDR_W-1:0] paddr,
	input  logic [mapd_pkg::PDATA_W-1:0] pwdata,
	output logic [mapd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	localparam int WINDOW = 1 << WINDOW_LOG2;
	localparam int DW = mapd_pkg::DATA_W;

	// ------------------------------------------------------------------
	// Configuration register: peak threshold at byte address 0.
	// Only the word select bit is decoded; byte offsets alias.
	// ------------------------------------------------------------------
	logic [DW-1:0] thr_q;
	logic          reg_sel;

	assign reg_sel = (paddr[mapd_pkg::PADDR_W-1] == mapd_pkg::REG_PEAK_THRESHOLD[
		mapd_pkg::PADDR_W-1]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			thr_q <= pwdata[DW-1:0];
		end
	end

	assign prdata = reg_sel ? {(mapd_pkg::PDATA_W - DW)'(0), thr_q} : '0;

	// ------------------------------------------------------------------
	// Handshake: the output register parts the two sides. Accept a new
	// sample whenever the held result is empty or leaves this cycle.
	// ------------------------------------------------------------------
	logic                in_acc;
	logic                out_valid_q;
	mapd_pkg::mapd_res_t res, res_q;
	mapd_pkg::mapd_ctl_t ctl, head_ctl;

	assign samples.ready = !out_valid_q || results.ready;
	assign in_acc        = samples.valid && samples.ready;
	assign ctl.adv       = in_acc;
	assign ctl.clr       = samples.restart;
	// The head cell always loads the new sample, even on restart
	assign head_ctl.adv  = in_acc;
	assign head_ctl.clr  = 1'b0;

	// ------------------------------------------------------------------
	// Window: a chain of cells, each handing its sample to the next one on
	// every accepted beat. The last cell holds the sample that leaves.
	// ------------------------------------------------------------------
	logic [DW-1:0] tap [WINDOW];

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			mapd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (head_ctl),
				.d      (samples.sample),
				.q      (tap[i])
			);
		end else begin : g_body
			mapd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.d      (tap[i-1]),
				.q      (tap[i])
			);
		end
	end

	// ------------------------------------------------------------------
	// Running sum, average, position count and peak compare
	// ------------------------------------------------------------------
	mapd_stat #(
		.WINDOW_LOG2 (WINDOW_LOG2)
	) u_stat (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sample    (samples.sample),
		.oldest    (tap[WINDOW-1]),
		.threshold (thr_q),
		.res       (res)
	);

	// ------------------------------------------------------------------
	// Result register: load on an accepted beat, drop once taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.average       = res_q.average;
	assign results.average_valid = res_q.average_valid;
	assign results.peak_found    = res_q.peak_found;
	assign results.peak_index    = res_q.peak_index;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A restart beat begins warm-up: its result carries no average
	a_restart_warmup: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && samples.restart |=> out_valid_q && !res_q.average_valid)
		else $error("restart beat produced a valid average");

	// During warm-up the average and peak fields stay clear
	a_warmup_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.average_valid |-> res_q.average == '0 && !res_q.peak_found)
		else $error("warm-up result carries average or peak");

	// Without a peak the index field stays clear
	a_peak_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.peak_found |-> res_q.peak_index == '0)
		else $error("peak index set without a peak");

	// A held result waits unchanged while the sink stalls
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !results.ready |=> out_valid_q && $stable(res_q))
		else $error("result register changed under stall");

endmodule

// File: verif/moving_average_peak_checker.sv
`timescale 1ns / 1ps
module moving_average_peak_checker
	import mapd_pkg::*;
#(
	parameter int WINDOW_LOG2 = WINDOW_LOG2_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	mapd_in_if                 samples,
	mapd_out_if                results,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 outstanding
);

	localparam int WINDOW  = 1 << WINDOW_LOG2;
	localparam int SUM_W   = DATA_W + WINDOW_LOG2;
	localparam int IDX_TOP = (1 << DATA_W) - 1;

	logic [DATA_W-1:0] taps [WINDOW];
	int unsigned       tap_ptr;
	logic [SUM_W-1:0]  window_sum;
	int                position;
	logic [DATA_W-1:0] last_avg;
	logic [DATA_W-1:0] older_avg;
	logic [DATA_W-1:0] threshold;
	mapd_res_t         predicted_averages [$];

	function automatic void clear_window();
		for (int i = 0; i < WINDOW; i++)
			taps[i] = '0;
		tap_ptr    = 0;
		window_sum = '0;
		position   = -WINDOW;
		last_avg   = '0;
		older_avg  = '0;
	endfunction

	// Advance the filter by one sample and return the result beat it causes.
	function automatic mapd_res_t next_average(input logic [DATA_W-1:0] value,
		input logic restart);
		mapd_res_t r;
		int        idx;
		r = '0;
		if (restart)
			clear_window();
		window_sum    = window_sum + SUM_W'(value) - SUM_W'(taps[tap_ptr]);
		taps[tap_ptr] = value;
		tap_ptr       = (tap_ptr + 1) % WINDOW;
		if (position < POS_LIMIT)
			position++;
		if (position >= 0) begin
			r.average_valid = 1'b1;
			r.average       = DATA_W'(window_sum >> WINDOW_LOG2);
			if (older_avg <= last_avg && r.average < last_avg && last_avg >= threshold) begin
				r.peak_found = 1'b1;
				idx          = (position > 0) ? position - 1 : 0;
				r.peak_index = (idx > IDX_TOP) ? DATA_W'(IDX_TOP) : DATA_W'(idx);
			end
			older_avg = last_avg;
			last_avg  = r.average;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mapd_res_t got;
		mapd_res_t want;
		if (!arst_n) begin
			clear_window();
			threshold = '0;
			predicted_averages.delete();
			outstanding = 0;
		end else begin
			// retire result beats before taking new samples: a result never
			// belongs to a sample accepted at the same edge
			if (results.valid && results.ready) begin
				got.average       = results.average;
				got.average_valid = results.average_valid;
				got.peak_found    = results.peak_found;
				got.peak_index    = results.peak_index;
				if (predicted_averages.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result beat with nothing pending: avg %0d valid %0b peak %0b idx %0d",
							$realtime, got.average, got.average_valid, got.peak_found,
							got.peak_index);
					mismatches++;
				end else begin
					want = predicted_averages.pop_front();
					if (got.average !== want.average || got.average_valid !== want.average_valid ||
						got.peak_found !== want.peak_found || got.peak_index !== want.peak_index) begin
						if (mismatches < 10)
							$display("%0t: mismatch avg %0d/%0d valid %0b/%0b peak %0b/%0b idx %0d/%0d (exp/act)",
								$realtime, want.average, got.average, want.average_valid,
								got.average_valid, want.peak_found, got.peak_found,
								want.peak_index, got.peak_index);
						mismatches++;
					end
				end
			end
			if (psel && penable && pready && paddr == REG_PEAK_THRESHOLD) begin
				if (pwrite) begin
					threshold = pwdata[DATA_W-1:0];
				end else if (prdata !== PDATA_W'(threshold)) begin
					if (mismatches < 10)
						$display("%0t: threshold readback exp %0d act %0d",
							$realtime, threshold, prdata);
					mismatches++;
				end
			end
			if (samples.valid && samples.ready)
				predicted_averages.push_back(next_average(samples.sample, samples.restart));
			outstanding = predicted_averages.size();
		end
	end

endmodule

// File: verif/moving_average_peak_detector_tb.sv
`timescale 1ns / 1ps
module moving_average_peak_detector_tb;
	import mapd_pkg::*;

	// Output-side stall patterns, reselected at random by the receiver
	typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_BLOCKS} rx_pattern_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 mismatches;
	int                 outstanding;

	// sender burst bookkeeping; steady turns off the gaps between bursts
	int                 burst_left;
	bit                 steady;

	int                 rx_cycle;
	rx_pattern_t        rx_mode;

	mapd_in_if  in_ch ();
	mapd_out_if out_ch ();

	moving_average_peak_detector DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (in_ch),
		.results (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// The checker watches both channels and the register port on its own;
	// this module only makes stimulus and gives the verdict.
	moving_average_peak_checker peak_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (in_ch),
		.results     (out_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	// Receiver: stall on a pattern of its own, independent of the sender.
	// Every pattern but the coin toss lets at least a quarter of the cycles through.
	always @(negedge clk) begin
		rx_cycle = rx_cycle + 1;
		if (rx_cycle % 32 == 0)
			rx_mode = rx_pattern_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:  out_ch.ready <= 1'b1;
			RX_COIN:  out_ch.ready <= 1'($urandom_range(0, 1));
			RX_THIRD: out_ch.ready <= (rx_cycle % 3 == 0);
			default:  out_ch.ready <= (rx_cycle % 8 >= 6);
		endcase
	end

	// Offer one sample beat and hold it until accepted. Open a new burst
	// with a random gap first when the current one is used up. Return at
	// the falling edge after acceptance with valid still high, so that
	// back-to-back beats never drop valid in between.
	task automatic send_sample(input logic [DATA_W-1:0] value, input logic fresh);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		in_ch.valid   <= 1'b1;
		in_ch.sample  <= value;
		in_ch.restart <= fresh;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		burst_left--;
		@(negedge clk);
	endtask

	// One register transfer: setup phase, access phase, then an idle phase
	// so that a following transfer never reassigns psel in the same step.
	task automatic reg_access(input logic write, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= REG_PEAK_THRESHOLD;
		pwdata  <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Write the threshold, then read it back for the checker to compare.
	task automatic set_threshold(input logic [DATA_W-1:0] value);
		reg_access(1'b1, value);
		reg_access(1'b0, '0);
	endtask

	// Drop valid, wait for every predicted result to arrive, then leave the
	// pipeline idle before touching the registers.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Random sequence: mostly a bounded random walk, so averages rise and
	// fall and form real peaks, salted with full-range noise, rail values
	// and, where noisy is set, rare restarts that break the sequence.
	task automatic run_phase(input int count, input bit fresh, input bit noisy);
		int                level;
		int                roll;
		logic [DATA_W-1:0] value;
		logic              restart;
		level = $urandom_range(0, 65535);
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				value = DATA_W'($urandom);
			end else if (roll < 12) begin
				value = roll[0] ? 16'hFFFF : 16'h0000;
			end else begin
				level = level + int'($urandom_range(0, 8192)) - 4096;
				if (level < 0)
					level = 0;
				if (level > 65535)
					level = 65535;
				value = DATA_W'(level);
			end
			restart = (n == 0 && fresh) || (noisy && $urandom_range(0, 199) == 0);
			send_sample(value, restart);
		end
		wait_idle();
	endtask

	initial begin
		logic [DATA_W-1:0] thresholds [8];
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_ch.valid   = 1'b0;
		in_ch.sample  = '0;
		in_ch.restart = 1'b0;
		out_ch.ready  = 1'b0;
		burst_left    = 0;
		steady        = 1'b0;
		rx_cycle      = 0;
		rx_mode       = RX_OPEN;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// threshold must read back as zero out of reset
		reg_access(1'b0, '0);

		// Full-scale window under the top threshold: the first average
		// cannot peak, a plateau does not peak, and the drop flags a peak
		// whose average equals the threshold exactly.
		set_threshold(16'hFFFF);
		send_sample(16'hFFFF, 1'b1);
		repeat (8) send_sample(16'hFFFF, 1'b0);
		repeat (2) send_sample(16'h0000, 1'b0);
		wait_idle();

		// Restart, then restart again in the middle of warm-up; a ramp up
		// and a drop flag a peak at a known index with a zero threshold.
		set_threshold(16'h0000);
		send_sample(16'h00FF, 1'b1);
		send_sample(16'hFF00, 1'b0);
		send_sample(16'h8000, 1'b1);
		repeat (7) send_sample(16'h8000, 1'b0);
		repeat (2) send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		wait_idle();

		// Random phases, each under its own threshold setting.
		thresholds = '{16'hFFFF, DATA_W'($urandom), 16'h8000, DATA_W'($urandom),
			16'h0001, DATA_W'($urandom), DATA_W'($urandom), 16'h0000};
		foreach (thresholds[i]) begin
			set_threshold(thresholds[i]);
			run_phase(150, 1'($urandom_range(0, 1)), 1'b1);
		end

		// One unbroken run with the sender at full rate.
		set_threshold(DATA_W'($urandom_range(0, 255)));
		steady = 1'b1;
		run_phase(150, 1'b1, 1'b0);

		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
